### hdl/cpl_pkg.sv
package cpl_pkg;

   // coordinate format
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // derived arithmetic widths
   localparam int CW  = COORD_WIDTH;
   localparam int EW  = CW + 1;              // origin difference
   localparam int PRW = CW + EW;             // one coordinate product
   localparam int DW  = 2 * CW + 3;          // dot products
   localparam int LB  = (DW + 1) / 2;        // low limb of a dot product
   localparam int HB  = DW - LB;             // high limb of a dot product
   localparam int MW  = LB + 1 + HB;         // mixed limb product
   localparam int NW  = 2 * DW + 1;          // determinant and numerators
   localparam int ML  = 32;                  // numerator limb for scaling
   localparam int NL  = (NW + ML - 1) / ML;  // numerator limb count
   localparam int TL  = NW - (NL - 1) * ML;  // top numerator limb
   localparam int PPW = ML + 1 + CW;         // scaling partial product
   localparam int PW  = NW + CW;             // direction times numerator
   localparam int QB  = CW + 1;              // quotient bits before overrange
   localparam int RW  = ((PW > NW + QB) ? PW : NW + QB) + 1;
   localparam int SW  = CW + 3;              // origin plus offset

   localparam int THR_SHIFT = 4 * FRAC_BITS - 32;
   localparam int DIV_LAT   = QB + 3;
   localparam int LANES     = 6;

   localparam logic [31:0] THR_RESET = 32'd512;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_PARALLEL = 2'd1;
   localparam logic [1:0] STATUS_SAT      = 2'd2;

   // field groups in input order
   localparam int F_O1 = 0;
   localparam int F_D1 = 3;
   localparam int F_O2 = 6;
   localparam int F_D2 = 9;

   typedef struct packed {
      logic signed [CW-1:0] first_origin_x;
      logic signed [CW-1:0] first_origin_y;
      logic signed [CW-1:0] first_origin_z;
      logic signed [CW-1:0] first_dir_x;
      logic signed [CW-1:0] first_dir_y;
      logic signed [CW-1:0] first_dir_z;
      logic signed [CW-1:0] second_origin_x;
      logic signed [CW-1:0] second_origin_y;
      logic signed [CW-1:0] second_origin_z;
      logic signed [CW-1:0] second_dir_x;
      logic signed [CW-1:0] second_dir_y;
      logic signed [CW-1:0] second_dir_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] near1_x;
      logic signed [CW-1:0] near1_y;
      logic signed [CW-1:0] near1_z;
      logic signed [CW-1:0] near2_x;
      logic signed [CW-1:0] near2_y;
      logic signed [CW-1:0] near2_z;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] c;
      logic signed [DW-1:0] g;
      logic signed [DW-1:0] p;
      logic signed [DW-1:0] q;
   } dots_type;

   typedef struct packed {
      logic [NW-1:0]        den;
      logic signed [NW-1:0] n1;
      logic signed [NW-1:0] n2;
      logic                 par;
   } solve_type;

   typedef struct packed {
      logic [PW-1:0]        mag;
      logic                 neg;
      logic [NW-1:0]        den;
      logic signed [CW-1:0] org;
   } lane_type;

   typedef struct packed {
      logic signed [CW-1:0] coord;
      logic                 sat;
   } lane_out_type;

   // input field by position in the item
   function automatic logic signed [CW-1:0] req_field(req_type r, int idx);
      logic signed [CW-1:0] f;
      case (idx)
         0:       f = r.first_origin_x;
         1:       f = r.first_origin_y;
         2:       f = r.first_origin_z;
         3:       f = r.first_dir_x;
         4:       f = r.first_dir_y;
         5:       f = r.first_dir_z;
         6:       f = r.second_origin_x;
         7:       f = r.second_origin_y;
         8:       f = r.second_origin_z;
         9:       f = r.second_dir_x;
         10:      f = r.second_dir_y;
         11:      f = r.second_dir_z;
         default: f = r.first_origin_x;
      endcase
      return f;
   endfunction

endpackage

### hdl/cpl_dot.sv
module cpl_dot import cpl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_item,
   output logic     out_valid,
   output req_type  out_item,
   output dots_type out_dots
);

   logic                  v1_ff, v2_ff, v3_ff;
   req_type               item1_ff, item2_ff, item3_ff;
   logic signed [EW-1:0]  e_in  [3];
   logic signed [EW-1:0]  e1_ff [3];
   logic signed [PRW-1:0] pa_in [3], pc_in [3], pg_in [3], pp_in [3], pq_in [3];
   logic signed [PRW-1:0] pa_ff [3], pc_ff [3], pg_ff [3], pp_ff [3], pq_ff [3];
   dots_type              dots_in, dots_ff;

   // origin difference
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e_in[k] = EW'(req_field(in_item, F_O2 + k)) - EW'(req_field(in_item, F_O1 + k));
      end
   end

   // per-coordinate products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pa_in[k] = PRW'(req_field(item1_ff, F_D1 + k)) * PRW'(req_field(item1_ff, F_D1 + k));
         pc_in[k] = PRW'(req_field(item1_ff, F_D1 + k)) * PRW'(req_field(item1_ff, F_D2 + k));
         pg_in[k] = PRW'(req_field(item1_ff, F_D2 + k)) * PRW'(req_field(item1_ff, F_D2 + k));
         pp_in[k] = PRW'(req_field(item1_ff, F_D1 + k)) * PRW'(e1_ff[k]);
         pq_in[k] = PRW'(req_field(item1_ff, F_D2 + k)) * PRW'(e1_ff[k]);
      end
   end

   // three-term sums
   always_comb begin
      dots_in.a = DW'(pa_ff[0]) + DW'(pa_ff[1]) + DW'(pa_ff[2]);
      dots_in.c = DW'(pc_ff[0]) + DW'(pc_ff[1]) + DW'(pc_ff[2]);
      dots_in.g = DW'(pg_ff[0]) + DW'(pg_ff[1]) + DW'(pg_ff[2]);
      dots_in.p = DW'(pp_ff[0]) + DW'(pp_ff[1]) + DW'(pp_ff[2]);
      dots_in.q = DW'(pq_ff[0]) + DW'(pq_ff[1]) + DW'(pq_ff[2]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item1_ff <= in_item;
      item2_ff <= item1_ff;
      item3_ff <= item2_ff;
      e1_ff    <= e_in;
      pa_ff    <= pa_in;
      pc_ff    <= pc_in;
      pg_ff    <= pg_in;
      pp_ff    <= pp_in;
      pq_ff    <= pq_in;
      dots_ff  <= dots_in;
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;
   assign out_dots  = dots_ff;

endmodule

### hdl/cpl_solve.sv
module cpl_solve import cpl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  req_type     in_item,
   input  dots_type    in_dots,
   input  logic [31:0] threshold,
   output logic        out_valid,
   output req_type     out_item,
   output solve_type   out_solve
);

   logic                   v4_ff, v5_ff, v6_ff, v7_ff;
   req_type                item4_ff, item5_ff, item6_ff, item7_ff;
   logic signed [DW-1:0]   x [6];
   logic signed [DW-1:0]   y [6];
   logic [2*LB-1:0]        ll_in [6], ll_ff [6];
   logic signed [MW-1:0]   lh_in [6], lh_ff [6];
   logic signed [MW-1:0]   hl_in [6], hl_ff [6];
   logic signed [2*HB-1:0] hh_in [6], hh_ff [6];
   logic signed [NW-1:0]   prod_in [6], prod_ff [6];
   logic signed [NW-1:0]   det_in, det_ff, n1_in, n1_ff, n2_in, n2_ff;
   logic signed [NW-1:0]   thr_pos, thr_neg;
   solve_type              solve_in, solve_ff;

   // operand pairs: c*c, a*g, c*q, g*p, a*q, c*p
   always_comb begin
      x[0] = in_dots.c;  y[0] = in_dots.c;
      x[1] = in_dots.a;  y[1] = in_dots.g;
      x[2] = in_dots.c;  y[2] = in_dots.q;
      x[3] = in_dots.g;  y[3] = in_dots.p;
      x[4] = in_dots.a;  y[4] = in_dots.q;
      x[5] = in_dots.c;  y[5] = in_dots.p;
   end

   // limb partial products
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         ll_in[j] = (2*LB)'(x[j][LB-1:0]) * (2*LB)'(y[j][LB-1:0]);
         lh_in[j] = MW'($signed({1'b0, x[j][LB-1:0]})) * MW'($signed(y[j][DW-1:LB]));
         hl_in[j] = MW'($signed(x[j][DW-1:LB])) * MW'($signed({1'b0, y[j][LB-1:0]}));
         hh_in[j] = (2*HB)'($signed(x[j][DW-1:LB])) * (2*HB)'($signed(y[j][DW-1:LB]));
      end
   end

   // assemble full products
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         prod_in[j] = (NW'(hh_ff[j]) <<< (2 * LB))
                    + ((NW'(lh_ff[j]) + NW'(hl_ff[j])) <<< LB)
                    + NW'($signed({1'b0, ll_ff[j]}));
      end
   end

   // cramer terms
   always_comb begin
      det_in = prod_ff[0] - prod_ff[1];
      n1_in  = prod_ff[2] - prod_ff[3];
      n2_in  = prod_ff[4] - prod_ff[5];
   end

   // parallel test and sign normalization
   always_comb begin
      thr_pos      = $signed(NW'(threshold) << THR_SHIFT);
      thr_neg      = -thr_pos;
      solve_in.par = (det_ff == '0) || ((det_ff < thr_pos) && (det_ff > thr_neg));
      solve_in.den = det_ff[NW-1] ? $unsigned(-det_ff) : $unsigned(det_ff);
      solve_in.n1  = det_ff[NW-1] ? -n1_ff : n1_ff;
      solve_in.n2  = det_ff[NW-1] ? -n2_ff : n2_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item4_ff <= in_item;
      item5_ff <= item4_ff;
      item6_ff <= item5_ff;
      item7_ff <= item6_ff;
      ll_ff    <= ll_in;
      lh_ff    <= lh_in;
      hl_ff    <= hl_in;
      hh_ff    <= hh_in;
      prod_ff  <= prod_in;
      det_ff   <= det_in;
      n1_ff    <= n1_in;
      n2_ff    <= n2_in;
      solve_ff <= solve_in;
   end

   assign out_valid = v7_ff;
   assign out_item  = item7_ff;
   assign out_solve = solve_ff;

endmodule

### hdl/cpl_scale.sv
module cpl_scale import cpl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  req_type   in_item,
   input  solve_type in_solve,
   output logic      out_valid,
   output logic      out_par,
   output lane_type  out_lane [LANES]
);

   logic                 v8_ff, v9_ff, v10_ff;
   logic                 par8_ff, par9_ff, par10_ff;
   logic signed [NW-1:0] lnum [LANES];
   logic signed [CW-1:0] ldir [LANES];
   logic signed [CW-1:0] lorg [LANES];
   logic signed [PPW-1:0] pp_in [LANES][NL];
   logic signed [PPW-1:0] pp_ff [LANES][NL];
   logic [NW-1:0]        den8_ff, den9_ff;
   logic signed [CW-1:0] org8_ff [LANES], org9_ff [LANES];
   logic signed [PW-1:0] prod_in [LANES], prod_ff [LANES];
   lane_type             lane_in [LANES], lane_ff [LANES];

   // lane operands: first line on lanes 0..2, second on 3..5
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         lnum[l]     = in_solve.n1;
         ldir[l]     = req_field(in_item, F_D1 + l);
         lorg[l]     = req_field(in_item, F_O1 + l);
         lnum[l + 3] = in_solve.n2;
         ldir[l + 3] = req_field(in_item, F_D2 + l);
         lorg[l + 3] = req_field(in_item, F_O2 + l);
      end
   end

   // numerator limbs times direction
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         for (int i = 0; i < NL - 1; i++) begin
            pp_in[l][i] = PPW'($signed({1'b0, lnum[l][i*ML +: ML]})) * PPW'(ldir[l]);
         end
         pp_in[l][NL-1] = PPW'($signed(lnum[l][NW-1 -: TL])) * PPW'(ldir[l]);
      end
   end

   // weighted sum of limb products
   always_comb begin
      logic signed [PW-1:0] acc;
      for (int l = 0; l < LANES; l++) begin
         acc = '0;
         for (int i = 0; i < NL; i++) begin
            acc = acc + (PW'(pp_ff[l][i]) <<< (i * ML));
         end
         prod_in[l] = acc;
      end
   end

   // sign and magnitude for the divider
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_in[l].neg = prod_ff[l][PW-1];
         lane_in[l].mag = prod_ff[l][PW-1] ? $unsigned(-prod_ff[l]) : $unsigned(prod_ff[l]);
         lane_in[l].den = den9_ff;
         lane_in[l].org = org9_ff[l];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else begin
         v8_ff  <= in_valid;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pp_ff    <= pp_in;
      par8_ff  <= in_solve.par;
      par9_ff  <= par8_ff;
      par10_ff <= par9_ff;
      den8_ff  <= in_solve.den;
      den9_ff  <= den8_ff;
      org8_ff  <= lorg;
      org9_ff  <= org8_ff;
      prod_ff  <= prod_in;
      lane_ff  <= lane_in;
   end

   assign out_valid = v10_ff;
   assign out_par   = par10_ff;
   assign out_lane  = lane_ff;

endmodule

### hdl/cpl_div.sv
module cpl_div import cpl_pkg::*; (
   input  logic         clock,
   input  lane_type     in_lane,
   output lane_out_type out_res
);

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [SW-1:0] SMAX = SW'(CMAX);
   localparam logic signed [SW-1:0] SMIN = SW'(CMIN);

   logic [PW-1:0]        rem_ff  [QB+1];
   logic [QB-1:0]        quo_ff  [QB+1];
   logic [NW-1:0]        den_ff  [QB+1];
   logic                 neg_ff  [QB+1];
   logic                 over_ff [QB+1];
   logic signed [CW-1:0] org_ff  [QB+1];
   logic                 over_in;
   logic [QB:0]          qr_in, qr_ff;
   logic                 negr_ff, overr_ff;
   logic signed [CW-1:0] orgr_ff;
   logic signed [SW-1:0] off, sum;
   lane_out_type         res_in, res_ff;

   // quotient would not fit: result is out of range anyway
   assign over_in = RW'(in_lane.mag) >= (RW'(in_lane.den) << QB);

   always_ff @(posedge clock) begin
      rem_ff[0]  <= in_lane.mag;
      quo_ff[0]  <= '0;
      den_ff[0]  <= in_lane.den;
      neg_ff[0]  <= in_lane.neg;
      over_ff[0] <= over_in;
      org_ff[0]  <= in_lane.org;
   end

   // restoring division, one quotient bit per stage
   for (genvar i = 0; i < QB; i++) begin : g_bit
      localparam int K = QB - 1 - i;
      logic [RW-1:0] trial;
      logic          fit;
      logic [PW-1:0] rem_in;

      always_comb begin
         trial  = RW'(den_ff[i]) << K;
         fit    = RW'(rem_ff[i]) >= trial;
         rem_in = fit ? PW'(RW'(rem_ff[i]) - trial) : rem_ff[i];
      end

      always_ff @(posedge clock) begin
         rem_ff[i+1]  <= rem_in;
         quo_ff[i+1]  <= {quo_ff[i][QB-2:0], fit};
         den_ff[i+1]  <= den_ff[i];
         neg_ff[i+1]  <= neg_ff[i];
         over_ff[i+1] <= over_ff[i];
         org_ff[i+1]  <= org_ff[i];
      end
   end

   // round half away from zero on the magnitude
   assign qr_in = (QB+1)'(quo_ff[QB])
                + (QB+1)'(RW'({rem_ff[QB], 1'b0}) >= RW'(den_ff[QB]));

   always_ff @(posedge clock) begin
      qr_ff    <= qr_in;
      negr_ff  <= neg_ff[QB];
      overr_ff <= over_ff[QB];
      orgr_ff  <= org_ff[QB];
   end

   // add to origin and clamp
   always_comb begin
      off = negr_ff ? -$signed(SW'(qr_ff)) : $signed(SW'(qr_ff));
      sum = SW'(orgr_ff) + off;
      if (overr_ff) begin
         res_in.coord = negr_ff ? CMIN : CMAX;
         res_in.sat   = 1'b1;
      end else if (sum > SMAX) begin
         res_in.coord = CMAX;
         res_in.sat   = 1'b1;
      end else if (sum < SMIN) begin
         res_in.coord = CMIN;
         res_in.sat   = 1'b1;
      end else begin
         res_in.coord = sum[CW-1:0];
         res_in.sat   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_res = res_ff;

endmodule

### hdl/closest_points_two_lines_3d.sv
// Closest points between two 3D lines in signed Q16.16. A pair of lines
// (origin and direction each) is taken at every clock edge where start is
// high; busy is always low, so one pair per clock is sustained. Each result
// is marked by rsp_strobe for one cycle, in input order; the receiver cannot
// stall and must take every beat. A pair passes through ten stages of dot
// products, limb multipliers, determinant and scaling, then the 36 register
// stages of the divider path in each of the six coordinate lanes (input
// register, 33 quotient bits, rounding, clamp), then the output register.
// Status 1 means the lines are parallel (absolute determinant below
// parallel_threshold times 2^-32, or zero) and all points are zero; status 2
// means at least one coordinate saturated. Write the threshold through csr_
// only while no pair is in flight.
module closest_points_two_lines_3d import cpl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic         accept;
   logic [31:0]  thr_ff;
   logic         dot_valid, solve_valid, scale_valid, scale_par;
   req_type      dot_item, solve_item;
   dots_type     dot_res;
   solve_type    solve_res;
   lane_type     lanes [LANES];
   lane_out_type lane_res [LANES];
   logic         vd_ff [DIV_LAT];
   logic         pd_ff [DIV_LAT];
   logic         strobe_ff;
   rsp_type      rsp_in, rsp_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   cpl_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .out_valid (dot_valid),
      .out_item  (dot_item),
      .out_dots  (dot_res)
   );

   cpl_solve u_solve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_valid),
      .in_item   (dot_item),
      .in_dots   (dot_res),
      .threshold (thr_ff),
      .out_valid (solve_valid),
      .out_item  (solve_item),
      .out_solve (solve_res)
   );

   cpl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (solve_valid),
      .in_item   (solve_item),
      .in_solve  (solve_res),
      .out_valid (scale_valid),
      .out_par   (scale_par),
      .out_lane  (lanes)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      cpl_div u_div (
         .clock   (clock),
         .in_lane (lanes[l]),
         .out_res (lane_res[l])
      );
   end

   // valid and parallel flag alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_LAT; j++) vd_ff[j] <= 1'b0;
      end else begin
         vd_ff[0] <= scale_valid;
         for (int j = 1; j < DIV_LAT; j++) vd_ff[j] <= vd_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      pd_ff[0] <= scale_par;
      for (int j = 1; j < DIV_LAT; j++) pd_ff[j] <= pd_ff[j-1];
   end

   // result beat
   always_comb begin
      logic any_sat;
      any_sat = 1'b0;
      for (int l = 0; l < LANES; l++) any_sat = any_sat | lane_res[l].sat;
      if (pd_ff[DIV_LAT-1]) begin
         rsp_in.near1_x = '0;
         rsp_in.near1_y = '0;
         rsp_in.near1_z = '0;
         rsp_in.near2_x = '0;
         rsp_in.near2_y = '0;
         rsp_in.near2_z = '0;
         rsp_in.status  = STATUS_PARALLEL;
      end else begin
         rsp_in.near1_x = lane_res[0].coord;
         rsp_in.near1_y = lane_res[1].coord;
         rsp_in.near1_z = lane_res[2].coord;
         rsp_in.near2_x = lane_res[3].coord;
         rsp_in.near2_y = lane_res[4].coord;
         rsp_in.near2_z = lane_res[5].coord;
         rsp_in.status  = any_sat ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vd_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

### tb/closest_points_two_lines_3d_tb.sv
module closest_points_two_lines_3d_tb;
   import cpl_pkg::*;

   typedef logic signed [255:0] wide_t;

   // one row of the directed part
   typedef struct {
      req_type pair;
      bit      typed;
      rsp_type want;
   } pair_row_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   // typed expectation that replaces the predicted one for the current beat
   logic        pin_en;
   rsp_type     pin_rsp;

   logic [31:0] thr_model;
   rsp_type     pending_points[$];
   bit          failed;
   int          quiet_cycles;

   closest_points_two_lines_3d u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic wide_t widen(logic [CW-1:0] v);
      wide_t w;
      w = $signed(v);
      return w;
   endfunction

   // origin plus rounded dir*num/den, clamped to the coordinate range
   function automatic logic [CW-1:0] point_coord(wide_t org, wide_t dir, wide_t num,
                                                 wide_t den, inout bit sat);
      wide_t prod, mag, quo, rem, sum, hi, lo;
      bit    neg;
      prod = dir * num;
      neg  = prod < 0;
      mag  = neg ? -prod : prod;
      quo  = mag / den;
      rem  = mag % den;
      if (rem * 2 >= den) quo = quo + 1;
      if (neg) quo = -quo;
      sum = org + quo;
      hi  = widen(32'h7fffffff);
      lo  = widen(32'h80000000);
      if (sum > hi) begin
         sat = 1;
         return hi[CW-1:0];
      end
      if (sum < lo) begin
         sat = 1;
         return lo[CW-1:0];
      end
      return sum[CW-1:0];
   endfunction

   // closest points of both lines for one pair
   function automatic rsp_type nearest_points(req_type r, logic [31:0] thr);
      wide_t o1[3], d1[3], o2[3], d2[3], e[3];
      wide_t a, c, g, p, q, det, n1, n2, lim, mag;
      logic [CW-1:0] pt[6];
      rsp_type res;
      bit sat;
      sat = 0;
      a = 0; c = 0; g = 0; p = 0; q = 0;
      for (int k = 0; k < 3; k++) begin
         o1[k] = widen(r[12*CW-1-CW*k -: CW]);
         d1[k] = widen(r[12*CW-1-CW*(3+k) -: CW]);
         o2[k] = widen(r[12*CW-1-CW*(6+k) -: CW]);
         d2[k] = widen(r[12*CW-1-CW*(9+k) -: CW]);
         e[k]  = o2[k] - o1[k];
         a = a + d1[k] * d1[k];
         c = c + d1[k] * d2[k];
         g = g + d2[k] * d2[k];
         p = p + d1[k] * e[k];
         q = q + d2[k] * e[k];
      end
      det = c * c - a * g;
      n1  = c * q - g * p;
      n2  = a * q - c * p;
      lim = wide_t'({224'b0, thr}) << (4 * FRAC_BITS - 32);
      mag = det < 0 ? -det : det;
      if (det == 0 || mag < lim) begin
         res = '0;
         res.status = STATUS_PARALLEL;
         return res;
      end
      if (det < 0) begin
         det = -det;
         n1  = -n1;
         n2  = -n2;
      end
      for (int k = 0; k < 3; k++) begin
         pt[k]   = point_coord(o1[k], d1[k], n1, det, sat);
         pt[3+k] = point_coord(o2[k], d2[k], n2, det, sat);
      end
      res.near1_x = pt[0];
      res.near1_y = pt[1];
      res.near1_z = pt[2];
      res.near2_x = pt[3];
      res.near2_y = pt[4];
      res.near2_z = pt[5];
      res.status  = sat ? STATUS_SAT : STATUS_OK;
      return res;
   endfunction

   function automatic req_type make_pair(logic [CW-1:0] o1x, o1y, o1z, d1x, d1y, d1z,
                                         logic [CW-1:0] o2x, o2y, o2z, d2x, d2y, d2z);
      return {o1x, o1y, o1z, d1x, d1y, d1z, o2x, o2y, o2z, d2x, d2y, d2z};
   endfunction

   function automatic logic [CW-1:0] any_coord();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2:       return $urandom_range(0, 8) - 4;
         3, 4:    return ($urandom_range(0, 64) - 32) << 16;
         default: return $urandom;
      endcase
   endfunction

   // random pair: mostly well-formed lines with modest values, some raw noise
   function automatic req_type random_pair();
      logic [CW-1:0] f[12];
      int shape;
      shape = $urandom_range(0, 9);
      for (int k = 0; k < 12; k++) begin
         if (shape < 2) f[k] = $urandom;
         else if (shape < 4) f[k] = any_coord();
         else f[k] = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      end
      // near-parallel second direction
      if (shape >= 7) begin
         for (int k = 0; k < 3; k++)
            f[9+k] = f[3+k] + ($urandom_range(0, 64) - 32) * (shape == 9 ? 1 : 1024);
      end
      return {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic check_field(string name, logic [CW-1:0] got, logic [CW-1:0] want);
      if (got !== want) begin
         failed = 1;
         $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // take result beats and log accepted pairs
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_points.size() == 0) begin
            failed = 1;
            $display("%0t unexpected result beat actual %h", $time, rsp_item);
         end else begin
            want = pending_points.pop_front();
            check_field("near1_x", rsp_item.near1_x, want.near1_x);
            check_field("near1_y", rsp_item.near1_y, want.near1_y);
            check_field("near1_z", rsp_item.near1_z, want.near1_z);
            check_field("near2_x", rsp_item.near2_x, want.near2_x);
            check_field("near2_y", rsp_item.near2_y, want.near2_y);
            check_field("near2_z", rsp_item.near2_z, want.near2_z);
            check_field("status", 32'(rsp_item.status), 32'(want.status));
         end
      end
      if (!reset && start && !busy)
         pending_points.push_back(pin_en ? pin_rsp : nearest_points(req_item, thr_model));
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_pair(req_type pair, bit typed, rsp_type want, bit idle_on);
      int gap;
      req_item <= pair;
      pin_en   <= typed;
      pin_rsp  <= want;
      start    <= 1;
      do @(posedge clock); while (busy);
      gap = idle_on ? gap_len() : 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_threshold(logic [31:0] v);
      csr_data  <= v;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      thr_model = v;
   endtask

   initial begin
      pair_row_t rows[$];
      pair_row_t row;
      rsp_type   none;
      logic [31:0] thr_steps[4];
      bit idle_on;

      clock = 0;
      reset = 1;
      start = 0;
      req_item = '0;
      pin_en = 0;
      pin_rsp = '0;
      csr_valid = 0;
      csr_data = '0;
      thr_model = THR_RESET;
      failed = 0;
      quiet_cycles = 0;
      none = '0;

      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // all zero: parallel, points zero
      row.pair = '0; row.typed = 1; row.want = '0; row.want.status = STATUS_PARALLEL;
      rows.push_back(row);
      // identical directions: parallel
      row.pair = make_pair(0, 0, 0, 32'h10000, 0, 0, 32'h50000, 32'h10000, 0,
                           32'h10000, 0, 0);
      rows.push_back(row);
      // unit x axis against unit y line one unit above
      row.pair = make_pair(0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0);
      row.want = '0; row.want.near2_z = 32'h10000; row.want.status = STATUS_OK;
      rows.push_back(row);
      // extremes of every field
      row.typed = 0; row.want = none;
      row.pair = {12{32'h7fffffff}};
      rows.push_back(row);
      row.pair = {12{32'h80000000}};
      rows.push_back(row);
      row.pair = make_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                           32'h7fffffff, 1, 32'h80000000, 32'h7fffffff, 32'h80000000,
                           32'h7fffffff, 32'h80000000, 32'hffffffff);
      rows.push_back(row);
      row.pair = make_pair(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 0,
                           32'h10000, 0, 32'h80000000, 0);
      rows.push_back(row);
      // nearly parallel lines meeting far out: saturation
      row.pair = make_pair(0, 0, 0, 32'h40000000, 0, 0, 0, 32'h10000, 0,
                           32'h40000000, 1, 0);
      rows.push_back(row);
      // tie for rounding and negative determinant paths
      row.pair = make_pair(32'h8000, 1, 32'hffffffff, 3, 0, 0, 0, 32'h10000, 7,
                           0, 3, 1);
      rows.push_back(row);
      row.pair = make_pair(32'hffff0000, 32'h20000, 0, 32'hffff0000, 32'h10000, 0,
                           32'h30000, 0, 32'hfffe0000, 0, 32'hffff0000, 32'h10000);
      rows.push_back(row);
      // determinant well below the reset threshold: parallel
      row.pair = make_pair(0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 32'h200, 0);
      rows.push_back(row);
      row.pair = make_pair(0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 32'h1ff, 0);
      rows.push_back(row);

      foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].want, 1);
      drain();

      // random phases through several threshold settings
      thr_steps[0] = 32'h0;
      thr_steps[1] = 32'hffffffff;
      thr_steps[2] = $urandom;
      thr_steps[3] = THR_RESET;
      for (int ph = 0; ph < 4; ph++) begin
         write_threshold(thr_steps[ph]);
         for (int n = 0; n < 100; n++) begin
            if (n % 25 == 0) idle_on = $urandom_range(0, 3) != 0;
            send_pair(random_pair(), 0, none, idle_on);
            // sender holds off until the block is empty
            if (ph == 1 && n == 50) begin
               start <= 0;
               @(posedge clock);
               while (pending_points.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (!failed)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
